>>> hdl/rau_pkg.sv
// ----------------------------------------------------------------------------
// rau_pkg: shared types and constants of the rational arithmetic unit
// Operand width, request/result formats, opcode and status codes, the
// sequencer states and the shared adder interface.
// ----------------------------------------------------------------------------
package rau_pkg;

    localparam int WIDTH   = 32;            // operand width, 8..32
    localparam int FIELD_W = 32;            // width of the port fields
    localparam int M       = 2 * WIDTH;     // exact product / sum width
    localparam int ALU_W   = M + 1;         // shared adder width
    localparam int CNT_W   = $clog2(M);

    localparam logic [2:0] OP_NORM = 3'd0;
    localparam logic [2:0] OP_ADD  = 3'd1;
    localparam logic [2:0] OP_SUB  = 3'd2;
    localparam logic [2:0] OP_MUL  = 3'd3;
    localparam logic [2:0] OP_DIV  = 3'd4;
    localparam logic [2:0] OP_LT   = 3'd5;
    localparam logic [2:0] OP_GT   = 3'd6;
    localparam logic [2:0] OP_EQ   = 3'd7;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_ZERO = 2'd1;
    localparam logic [1:0] ST_OVF  = 2'd2;

    typedef struct packed {
        logic        [2:0]         opcode;
        logic signed [FIELD_W-1:0] a_num;
        logic signed [FIELD_W-1:0] a_den;
        logic signed [FIELD_W-1:0] b_num;
        logic signed [FIELD_W-1:0] b_den;
    } req_t;

    typedef struct packed {
        logic signed [FIELD_W-1:0] res_num;
        logic        [FIELD_W-2:0] res_den;
        logic                      cmp_true;
        logic        [1:0]         status;
    } rsl_t;

    typedef struct packed {
        logic             neg;
        logic [WIDTH-1:0] mag;
    } smag_t;

    typedef struct packed {
        logic [ALU_W-1:0] a;
        logic [ALU_W-1:0] b;
        logic             sub;
    } alu_in_t;

    typedef struct packed {
        logic             carry;    // a >= b when subtracting
        logic [ALU_W-1:0] res;
    } alu_out_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL,
        S_SUM,
        S_SUB2,
        S_EVAL,
        S_GSH,
        S_GU,
        S_GV,
        S_DIV,
        S_CHK,
        S_FIN
    } state_t;

    // Low WIDTH bits as two's complement, split into sign and magnitude
    function automatic smag_t to_smag(input logic [FIELD_W-1:0] raw);
        smag_t            r;
        logic [WIDTH-1:0] v;
        v     = raw[WIDTH-1:0];
        r.neg = v[WIDTH-1];
        r.mag = v[WIDTH-1] ? (~v + WIDTH'(1)) : v;
        return r;
    endfunction

endpackage

>>> hdl/rau_alu.sv
// ----------------------------------------------------------------------------
// rau_alu: shared add / subtract unit
// One wide adder with carry out; in subtract mode the carry flags a >= b.
// ----------------------------------------------------------------------------
module rau_alu (
    input  rau_pkg::alu_in_t  ctl,
    output rau_pkg::alu_out_t rsl
);
    import rau_pkg::*;

    logic [ALU_W-1:0] b_op;
    logic [ALU_W:0]   full;

    assign b_op = ctl.sub ? ~ctl.b : ctl.b;
    assign full = {1'b0, ctl.a} + {1'b0, b_op} + (ALU_W+1)'(ctl.sub);

    assign rsl.res   = full[ALU_W-1:0];
    assign rsl.carry = full[ALU_W];

endmodule

>>> hdl/rational_arithmetic_unit.sv
// ----------------------------------------------------------------------------
// rational_arithmetic_unit: exact fraction arithmetic and compare
// Normalize, add, subtract, multiply, divide and compare two fractions; the
// result is reduced by a binary gcd and carries a positive denominator.
//
//   channel | signals                           | direction
//   --------+-----------------------------------+----------
//   request | req_valid, req_stall, req_data    | in
//   result  | res_valid, res_stall, res_data    | out
//
// One request at a time; req_stall is high from acceptance until the result
// is moved into the output register. Errors go straight to the finish state;
// compares and zero results end once the sum is evaluated. Other results are
// reduced by the binary gcd loop on the shared adder, then a restoring divider
// on the same adder forms the two M-bit quotients (M = 2*WIDTH) in turn. The
// three products come from one WIDTH x WIDTH multiplier. A stalled result
// waits in the output register while the next request runs. Reset (rst_n
// low) empties the sequencer and the output register.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  rau_pkg::req_t req_data,
    output logic          res_valid,
    input  logic          res_stall,
    output rau_pkg::rsl_t res_data
);
    import rau_pkg::*;

    localparam logic [M-1:0] LIM = {{(M-WIDTH+1){1'b0}}, {(WIDTH-1){1'b1}}};

    state_t           state_reg, state_next;
    logic [2:0]       op_reg, op_next;
    smag_t            an_reg, an_next, ad_reg, ad_next;
    smag_t            bn_reg, bn_next, bd_reg, bd_next;
    logic [M-1:0]     nx_reg, nx_next, ny_reg, ny_next;
    logic [M-1:0]     n_reg, n_next, d_reg, d_next;
    logic [M-1:0]     u_reg, u_next, v_reg, v_next;
    logic [M-1:0]     q_reg, q_next, r_reg, r_next;
    logic             nx_neg_reg, nx_neg_next, ny_neg_reg, ny_neg_next;
    logic             n_neg_reg, n_neg_next, d_neg_reg, d_neg_next;
    logic             neg_reg, neg_next;
    logic             pass_reg, pass_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    rsl_t             rsl_reg, rsl_next;
    rsl_t             out_reg, out_next;
    logic             out_valid_reg, out_valid_next;

    smag_t            an_in, ad_in, bn_in, bd_in;
    logic             in_err;
    logic [WIDTH-1:0] mul_x, mul_y;
    logic [M-1:0]     prod;
    alu_in_t          alu_ctl;
    alu_out_t         alu_rsl;
    logic [M:0]       rem_sh;
    logic [M-1:0]     quo;
    logic             n_nz, neg_w, ovf;
    logic [M-1:0]     n_lim;
    logic [FIELD_W-1:0] num_w;
    logic             load_out;

    assign an_in = to_smag(req_data.a_num);
    assign ad_in = to_smag(req_data.a_den);
    assign bn_in = to_smag(req_data.b_num);
    assign bd_in = to_smag(req_data.b_den);
    assign in_err = (ad_in.mag == '0)
                 || ((req_data.opcode != OP_NORM) && (bd_in.mag == '0))
                 || ((req_data.opcode == OP_DIV) && (bn_in.mag == '0));

    assign prod   = mul_x * mul_y;
    assign rem_sh = {r_reg, q_reg[M-1]};
    assign quo    = {q_reg[M-2:0], alu_rsl.carry};
    assign n_nz   = (n_reg != '0);
    assign neg_w  = n_nz && (n_neg_reg != d_neg_reg);
    assign n_lim  = neg_reg ? (LIM + M'(1)) : LIM;
    assign ovf    = (d_reg > LIM) || (n_reg > n_lim);
    assign num_w  = neg_reg ? (~FIELD_W'(n_reg) + FIELD_W'(1)) : FIELD_W'(n_reg);

    rau_alu u_alu (
        .ctl (alu_ctl),
        .rsl (alu_rsl)
    );

    always_comb
    begin
        state_next  = state_reg;
        op_next     = op_reg;
        an_next     = an_reg;
        ad_next     = ad_reg;
        bn_next     = bn_reg;
        bd_next     = bd_reg;
        nx_next     = nx_reg;
        ny_next     = ny_reg;
        n_next      = n_reg;
        d_next      = d_reg;
        u_next      = u_reg;
        v_next      = v_reg;
        q_next      = q_reg;
        r_next      = r_reg;
        nx_neg_next = nx_neg_reg;
        ny_neg_next = ny_neg_reg;
        n_neg_next  = n_neg_reg;
        d_neg_next  = d_neg_reg;
        neg_next    = neg_reg;
        pass_next   = pass_reg;
        cnt_next    = cnt_reg;
        rsl_next    = rsl_reg;
        mul_x       = an_reg.mag;
        mul_y       = bd_reg.mag;
        alu_ctl.a   = {1'b0, v_reg};
        alu_ctl.b   = {1'b0, u_reg};
        alu_ctl.sub = 1'b1;
        load_out    = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    op_next = req_data.opcode;
                    an_next = an_in;
                    ad_next = ad_in;
                    bn_next = bn_in;
                    bd_next = bd_in;
                    cnt_next = '0;
                    if (in_err)
                    begin
                        rsl_next = '{res_num: '0, res_den: (FIELD_W-1)'(1),
                                     cmp_true: 1'b0, status: ST_ZERO};
                        state_next = S_FIN;
                    end
                    else if (req_data.opcode == OP_NORM)
                    begin
                        nx_next     = M'(an_in.mag);
                        nx_neg_next = an_in.neg;
                        d_next      = M'(ad_in.mag);
                        d_neg_next  = ad_in.neg;
                        state_next  = S_SUM;
                    end
                    else
                    begin
                        state_next = S_MUL;
                    end
                end
            end
            S_MUL:
            begin
                cnt_next = cnt_reg + CNT_W'(1);
                case (cnt_reg)
                    CNT_W'(0):
                    begin
                        mul_x = an_reg.mag;
                        mul_y = (op_reg == OP_MUL) ? bn_reg.mag : bd_reg.mag;
                        nx_next = prod;
                        nx_neg_next = an_reg.neg
                                    ^ ((op_reg == OP_MUL) ? bn_reg.neg : bd_reg.neg);
                    end
                    CNT_W'(1):
                    begin
                        // the right operand flips sign for subtract and compares
                        mul_x = bn_reg.mag;
                        mul_y = ad_reg.mag;
                        ny_next = prod;
                        ny_neg_next = bn_reg.neg ^ (op_reg != OP_ADD) ^ ad_reg.neg;
                    end
                    default:
                    begin
                        mul_x = ad_reg.mag;
                        mul_y = (op_reg == OP_DIV) ? bn_reg.mag : bd_reg.mag;
                        d_next = prod;
                        d_neg_next = ad_reg.neg
                                   ^ ((op_reg == OP_DIV) ? bn_reg.neg : bd_reg.neg);
                        state_next = S_SUM;
                    end
                endcase
            end
            S_SUM:
            begin
                alu_ctl.a   = {1'b0, nx_reg};
                alu_ctl.b   = {1'b0, ny_reg};
                alu_ctl.sub = (nx_neg_reg != ny_neg_reg);
                n_neg_next  = nx_neg_reg;
                state_next  = S_EVAL;
                if (op_reg inside {OP_NORM, OP_MUL, OP_DIV})
                begin
                    n_next = nx_reg;
                end
                else if (!alu_ctl.sub || alu_rsl.carry)
                begin
                    n_next = alu_rsl.res[M-1:0];
                end
                else
                begin
                    state_next = S_SUB2;
                end
            end
            S_SUB2:
            begin
                alu_ctl.a  = {1'b0, ny_reg};
                alu_ctl.b  = {1'b0, nx_reg};
                n_next     = alu_rsl.res[M-1:0];
                n_neg_next = ny_neg_reg;
                state_next = S_EVAL;
            end
            S_EVAL:
            begin
                neg_next = neg_w;
                if (op_reg inside {OP_LT, OP_GT, OP_EQ})
                begin
                    rsl_next = '{res_num: '0, res_den: (FIELD_W-1)'(1),
                                 cmp_true: 1'b0, status: ST_OK};
                    case (op_reg)
                        OP_LT:   rsl_next.cmp_true = neg_w;
                        OP_GT:   rsl_next.cmp_true = n_nz && !neg_w;
                        default: rsl_next.cmp_true = !n_nz;
                    endcase
                    state_next = S_FIN;
                end
                else if (!n_nz)
                begin
                    rsl_next = '{res_num: '0, res_den: (FIELD_W-1)'(1),
                                 cmp_true: 1'b0, status: ST_OK};
                    state_next = S_FIN;
                end
                else
                begin
                    state_next = S_GSH;
                end
            end
            S_GSH:
            begin
                // drop common factors of two from both; they cancel anyway
                if (!(n_reg[0] | d_reg[0]))
                begin
                    n_next = n_reg >> 1;
                    d_next = d_reg >> 1;
                end
                else
                begin
                    u_next     = n_reg;
                    v_next     = d_reg;
                    state_next = S_GU;
                end
            end
            S_GU:
            begin
                if (!u_reg[0])
                begin
                    u_next = u_reg >> 1;
                end
                else
                begin
                    state_next = S_GV;
                end
            end
            S_GV:
            begin
                if (v_reg == '0)
                begin
                    q_next     = n_reg;
                    r_next     = '0;
                    cnt_next   = '0;
                    pass_next  = 1'b0;
                    state_next = S_DIV;
                end
                else if (!v_reg[0])
                begin
                    v_next = v_reg >> 1;
                end
                else if (alu_rsl.carry)
                begin
                    v_next = alu_rsl.res[M-1:0];
                end
                else
                begin
                    // swap so that the larger one sits in v
                    u_next = v_reg;
                    v_next = u_reg;
                end
            end
            S_DIV:
            begin
                alu_ctl.a = rem_sh;
                alu_ctl.b = {1'b0, u_reg};
                r_next    = alu_rsl.carry ? alu_rsl.res[M-1:0] : rem_sh[M-1:0];
                q_next    = quo;
                cnt_next  = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(M-1))
                begin
                    cnt_next = '0;
                    r_next   = '0;
                    if (!pass_reg)
                    begin
                        n_next    = quo;
                        q_next    = d_reg;
                        pass_next = 1'b1;
                    end
                    else
                    begin
                        d_next     = quo;
                        state_next = S_CHK;
                    end
                end
            end
            S_CHK:
            begin
                if (ovf)
                begin
                    rsl_next = '{res_num: '0, res_den: (FIELD_W-1)'(1),
                                 cmp_true: 1'b0, status: ST_OVF};
                end
                else
                begin
                    rsl_next = '{res_num: num_w, res_den: (FIELD_W-1)'(d_reg),
                                 cmp_true: 1'b0, status: ST_OK};
                end
                state_next = S_FIN;
            end
            S_FIN:
            begin
                if (!out_valid_reg || !res_stall)
                begin
                    load_out   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        if (load_out)
        begin
            out_next       = rsl_reg;
            out_valid_next = 1'b1;
        end
        else if (!res_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        an_reg     <= an_next;
        ad_reg     <= ad_next;
        bn_reg     <= bn_next;
        bd_reg     <= bd_next;
        nx_reg     <= nx_next;
        ny_reg     <= ny_next;
        n_reg      <= n_next;
        d_reg      <= d_next;
        u_reg      <= u_next;
        v_reg      <= v_next;
        q_reg      <= q_next;
        r_reg      <= r_next;
        nx_neg_reg <= nx_neg_next;
        ny_neg_reg <= ny_neg_next;
        n_neg_reg  <= n_neg_next;
        d_neg_reg  <= d_neg_next;
        neg_reg    <= neg_next;
        pass_reg   <= pass_next;
        cnt_reg    <= cnt_next;
        rsl_reg    <= rsl_next;
        out_reg    <= out_next;
    end

    assign req_stall = (state_reg != S_IDLE);
    assign res_valid = out_valid_reg;
    assign res_data  = out_reg;

    a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall) |=> (state_reg != S_IDLE))
        else $error("sequencer idle right after an accepted request");

    a_gcd_u_odd: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_GV) |-> u_reg[0])
        else $error("gcd loop running with an even u");

    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> (u_reg != '0))
        else $error("divider running with a zero divisor");

    a_fail_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> ((res_data.status == ST_OK)
                    || ((res_data.res_num == '0) && (res_data.res_den == (FIELD_W-1)'(1)))))
        else $error("failed result does not read as 0/1");

endmodule

>>> verif/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the rational arithmetic unit
// Sends directed and random fraction requests over the valid/stall channel.
// An in-bench model predicts each reduced fraction, compare flag and status.
// Every returned result is checked field by field against the oldest
// prediction. Sender and receiver idle at random in changing proportions.
// ----------------------------------------------------------------------------
module tb_top;
    import rau_pkg::*;

    localparam int STALL_LIMIT = 5000;   // cycles with no transfer on either side
    localparam int DRAIN_WAIT  = 400;    // longer than the slowest reduction

    logic  clk       = 1'b0;
    logic  rst_n     = 1'b0;
    logic  req_valid = 1'b0;
    logic  req_stall;
    req_t  req_data  = '0;
    logic  res_valid;
    logic  res_stall = 1'b0;
    rsl_t  res_data;

    int    snd_idle_pct = 0;
    int    rcv_idle_pct = 0;
    int    mismatches   = 0;
    int    quiet_cycles = 0;
    rsl_t  pending_results[$];

    rational_arithmetic_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_data  (req_data),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_data  (res_data)
    );

    always #5 clk = ~clk;

    // Split the low WIDTH bits of a field into sign and magnitude
    function automatic void split_field(input logic [FIELD_W-1:0] raw, output bit neg,
                                        output logic [63:0] mag);
        logic [63:0] v;
        v   = 64'(raw[WIDTH-1:0]);
        neg = raw[WIDTH-1];
        mag = neg ? ((64'd1 << WIDTH) - v) : v;
    endfunction

    function automatic logic [63:0] common_divisor(input logic [63:0] u, input logic [63:0] v);
        logic [63:0] t;
        while (v != 0)
        begin
            t = u % v;
            u = v;
            v = t;
        end
        return u;
    endfunction

    function automatic rsl_t predict_result(input req_t r);
        rsl_t        res;
        bit          an_s, ad_s, bn_s, bd_s, p_s, q_s, n_s, d_s, neg;
        logic [63:0] an, ad, bn, bd, p, q, n, d, g, lim;
        res.res_num  = '0;
        res.res_den  = 31'd1;
        res.cmp_true = 1'b0;
        res.status   = ST_OK;
        split_field(r.a_num, an_s, an);
        split_field(r.a_den, ad_s, ad);
        split_field(r.b_num, bn_s, bn);
        split_field(r.b_den, bd_s, bd);
        if (ad == 0 || (r.opcode != OP_NORM && bd == 0) || (r.opcode == OP_DIV && bn == 0))
        begin
            res.status = ST_ZERO;
            return res;
        end
        case (r.opcode)
            OP_NORM:
            begin
                n = an;  n_s = an_s;
                d = ad;  d_s = ad_s;
            end
            OP_MUL:
            begin
                n = an * bn;  n_s = an_s ^ bn_s;
                d = ad * bd;  d_s = ad_s ^ bd_s;
            end
            OP_DIV:
            begin
                n = an * bd;  n_s = an_s ^ bd_s;
                d = ad * bn;  d_s = ad_s ^ bn_s;
            end
            default:
            begin
                // subtract and compare: add the negated right operand
                if (r.opcode != OP_ADD)
                    bn_s = !bn_s;
                p = an * bd;  p_s = an_s ^ bd_s;
                q = bn * ad;  q_s = bn_s ^ ad_s;
                if (p_s == q_s)
                begin
                    n = p + q;  n_s = p_s;
                end
                else if (p >= q)
                begin
                    n = p - q;  n_s = p_s;
                end
                else
                begin
                    n = q - p;  n_s = q_s;
                end
                d = ad * bd;  d_s = ad_s ^ bd_s;
            end
        endcase
        neg = (n != 0) && (n_s != d_s);
        if (r.opcode >= OP_LT)
        begin
            case (r.opcode)
                OP_LT:   res.cmp_true = neg;
                OP_GT:   res.cmp_true = (n != 0) && !neg;
                default: res.cmp_true = (n == 0);
            endcase
            return res;
        end
        if (n == 0)
            return res;
        g   = common_divisor(n, d);
        n   = n / g;
        d   = d / g;
        lim = (64'd1 << (WIDTH - 1)) - 64'd1;
        if (d > lim || n > lim + (neg ? 64'd1 : 64'd0))
        begin
            res.status = ST_OVF;
            return res;
        end
        res.res_num = FIELD_W'(neg ? (64'd0 - n) : n);
        res.res_den = d[FIELD_W-2:0];
        return res;
    endfunction

    function automatic req_t make_req(input logic [2:0] op, input logic [FIELD_W-1:0] an,
                                      input logic [FIELD_W-1:0] ad,
                                      input logic [FIELD_W-1:0] bn,
                                      input logic [FIELD_W-1:0] bd);
        req_t r;
        r.opcode = op;
        r.a_num  = an;
        r.a_den  = ad;
        r.b_num  = bn;
        r.b_den  = bd;
        return r;
    endfunction

    // Mix of small, mid-size, full-range, power-of-two and extreme operands
    function automatic logic [FIELD_W-1:0] pick_value(input bit nonzero);
        logic [FIELD_W-1:0] v;
        case ($urandom_range(5))
            0: v = FIELD_W'($urandom_range(40)) - FIELD_W'(20);
            1: v = FIELD_W'($urandom_range(65535)) - FIELD_W'(32768);
            2: v = FIELD_W'($urandom);
            3: v = FIELD_W'(1) << $urandom_range(FIELD_W - 1);
            4:
            begin
                case ($urandom_range(3))
                    0:       v = {1'b1, {(FIELD_W-1){1'b0}}};
                    1:       v = {1'b0, {(FIELD_W-1){1'b1}}};
                    2:       v = FIELD_W'(1);
                    default: v = '1;
                endcase
            end
            default: v = (FIELD_W'($urandom_range(60)) - FIELD_W'(30))
                         * FIELD_W'($urandom_range(4096, 1));
        endcase
        if ($urandom_range(1) == 1)
            v = -v;
        if (nonzero && v == 0)
            v = FIELD_W'(1);
        return v;
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance
    task automatic send_req(input req_t r);
        if ($urandom_range(99) < snd_idle_pct)
        begin
            req_valid <= 1'b0;
            do
                @(negedge clk);
            while ($urandom_range(99) < snd_idle_pct);
        end
        req_valid <= 1'b1;
        req_data  <= r;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic test_directed();
        localparam logic [FIELD_W-1:0] MINV = {1'b1, {(FIELD_W-1){1'b0}}};
        localparam logic [FIELD_W-1:0] MAXV = {1'b0, {(FIELD_W-1){1'b1}}};
        send_req(make_req(OP_NORM, 6, -4, 9, 0));          // right operand ignored
        send_req(make_req(OP_NORM, 0, -7, 0, 0));
        send_req(make_req(OP_NORM, MINV, 1, 0, 0));        // most negative fits
        send_req(make_req(OP_NORM, MINV, -1, 0, 0));       // negating it overflows
        send_req(make_req(OP_NORM, 5, MINV, 0, 0));        // denominator too large
        send_req(make_req(OP_NORM, 2, MINV, 0, 0));        // reduces back into range
        send_req(make_req(OP_NORM, 7, 0, 1, 1));           // zero denominator
        send_req(make_req(OP_NORM, '1, '1, '1, '1));
        send_req(make_req(OP_ADD, 1, 2, 1, 3));
        send_req(make_req(OP_ADD, MAXV, 1, MAXV, 1));
        send_req(make_req(OP_ADD, 1, 2, 1, 0));
        send_req(make_req(OP_SUB, 3, 4, 3, 4));            // zero result
        send_req(make_req(OP_SUB, MINV, 1, 1, 1));
        send_req(make_req(OP_MUL, MINV, MINV, MINV, MINV));
        send_req(make_req(OP_MUL, MAXV, 1, MAXV, 1));
        send_req(make_req(OP_DIV, 1, 2, 0, 5));            // divide by zero
        send_req(make_req(OP_DIV, -3, 4, 9, -8));
        send_req(make_req(OP_DIV, MAXV, MINV, MINV, MAXV));
        send_req(make_req(OP_LT, -1, 2, 1, 3));
        send_req(make_req(OP_LT, 2, 4, 1, 2));
        send_req(make_req(OP_GT, 1, 3, -1, 2));
        send_req(make_req(OP_GT, MINV, 1, MAXV, 1));
        send_req(make_req(OP_EQ, 2, 4, -3, -6));
        send_req(make_req(OP_EQ, 1, 1, 1, 0));
        send_req(make_req(OP_EQ, 0, 5, 0, -3));
    endtask

    // Well-formed fraction arithmetic, which runs the full reduction unless the result is zero
    task automatic test_reduction(input int count);
        req_t r;
        repeat (count)
        begin
            r.opcode = 3'($urandom_range(OP_DIV));
            r.a_num  = pick_value(1'b0);
            r.a_den  = pick_value(1'b1);
            r.b_num  = pick_value(r.opcode == OP_DIV);
            r.b_den  = pick_value(1'b1);
            send_req(r);
        end
    endtask

    // Comparisons with many equal and nearly equal pairs
    task automatic test_compare(input int count);
        req_t               r;
        logic [FIELD_W-1:0] k;
        repeat (count)
        begin
            r.opcode = OP_LT + 3'($urandom_range(2));
            r.a_num  = pick_value(1'b0);
            r.a_den  = pick_value(1'b1);
            case ($urandom_range(2))
                0:
                begin
                    k = FIELD_W'($urandom_range(7, 1));
                    if ($urandom_range(1) == 1)
                        k = -k;
                    r.b_num = r.a_num * k;
                    r.b_den = r.a_den * k;
                end
                1:
                begin
                    r.b_num = r.a_num + FIELD_W'($urandom_range(2)) - FIELD_W'(1);
                    r.b_den = r.a_den;
                end
                default:
                begin
                    r.b_num = pick_value(1'b0);
                    r.b_den = pick_value(1'b1);
                end
            endcase
            send_req(r);
        end
    endtask

    // Raw random requests, with zero fields forced now and then
    task automatic test_noise(input int count);
        req_t r;
        repeat (count)
        begin
            r.opcode = 3'($urandom_range(OP_EQ));
            r.a_num  = FIELD_W'($urandom);
            r.a_den  = FIELD_W'($urandom);
            r.b_num  = FIELD_W'($urandom);
            r.b_den  = FIELD_W'($urandom);
            if ($urandom_range(7) == 0)
                r.a_num = '0;
            if ($urandom_range(7) == 0)
                r.a_den = '0;
            if ($urandom_range(7) == 0)
                r.b_num = '0;
            if ($urandom_range(7) == 0)
                r.b_den = '0;
            send_req(r);
        end
    endtask

    always @(negedge clk)
        res_stall <= ($urandom_range(99) < rcv_idle_pct);

    // Check results, record predictions for accepted requests, watch for hangs
    always @(posedge clk)
    begin
        rsl_t want;
        bit   moved;
        moved = (req_valid && !req_stall) || (res_valid && !res_stall);
        if (rst_n && res_valid && !res_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result with no request outstanding: %h", res_data);
                mismatches++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (res_data.res_num !== want.res_num)
                begin
                    $error("res_num expected %0d actual %0d", want.res_num, res_data.res_num);
                    mismatches++;
                end
                if (res_data.res_den !== want.res_den)
                begin
                    $error("res_den expected %0d actual %0d", want.res_den, res_data.res_den);
                    mismatches++;
                end
                if (res_data.cmp_true !== want.cmp_true)
                begin
                    $error("cmp_true expected %0d actual %0d", want.cmp_true,
                           res_data.cmp_true);
                    mismatches++;
                end
                if (res_data.status !== want.status)
                begin
                    $error("status expected %0d actual %0d", want.status, res_data.status);
                    mismatches++;
                end
            end
        end
        if (rst_n && req_valid && !req_stall)
            pending_results = {pending_results, predict_result(req_data)};
        quiet_cycles = moved ? 0 : quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    initial
    begin
        repeat (5)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        snd_idle_pct = 23;
        rcv_idle_pct = 46;
        test_directed();
        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    snd_idle_pct = 23;
                    rcv_idle_pct = 46;
                end
                1:
                begin
                    snd_idle_pct = 46;
                    rcv_idle_pct = 23;
                end
                default:
                begin
                    snd_idle_pct = 0;
                    rcv_idle_pct = 0;
                end
            endcase
            test_reduction(200);
            test_compare(90);
            test_noise(125);
        end
        req_valid <= 1'b0;

        // drain, then hold a while to catch spurious results
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT)
            @(posedge clk);
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
